@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks on the clk / rst_n domain.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside of reset.
`define HILL_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define HILL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/hill_pkg.sv @@
// ---------------------------------------------------------------------------
// Hill cipher package
// Types and constants shared by the 2x2 mod 26 Hill cipher modules.
// ---------------------------------------------------------------------------
package hill_pkg;

  localparam int LETTER_W   = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  localparam logic [LETTER_W-1:0] MODULUS    = 5'd26;
  localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;

  typedef logic [LETTER_W-1:0] letter_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_A   = 3'd0,
    CFG_KEY_B   = 3'd1,
    CFG_KEY_C   = 3'd2,
    CFG_KEY_D   = 3'd3,
    CFG_DECRYPT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    letter_t a;
    letter_t b;
    letter_t c;
    letter_t d;
  } key_t;

  typedef struct packed {
    letter_t letter;
    logic    fin;
    logic    err;
  } result_t;

  typedef struct packed {
    result_t r0;
    result_t r1;
  } result_pair_t;

  // One multiply-accumulate step of the datapath sequence.
  typedef enum logic [3:0] {
    OP_E_AX = 4'd0,
    OP_E_BY = 4'd1,
    OP_E_CX = 4'd2,
    OP_E_DY = 4'd3,
    OP_D_BC = 4'd4,
    OP_D_AD = 4'd5,
    OP_D_BY = 4'd6,
    OP_D_DX = 4'd7,
    OP_D_R0 = 4'd8,
    OP_D_CX = 4'd9,
    OP_D_AY = 4'd10,
    OP_D_R1 = 4'd11
  } op_t;

  typedef struct packed {
    logic hold_first;
    logic capture;
    logic pad;
    logic mul_en;
    logic red_en;
    op_t  op;
  } cmd_t;

endpackage

@@ hw/rtl/hill_if.sv @@
// ---------------------------------------------------------------------------
// Hill cipher channels
// Valid/ready interfaces for the letter input and the result output.
// ---------------------------------------------------------------------------
interface hill_in_if import hill_pkg::*; ();
  logic    valid;
  logic    ready;
  letter_t letter_in;
  logic    end_of_message;

  modport source(output valid, output letter_in, output end_of_message, input ready);
  modport sink(input valid, input letter_in, input end_of_message, output ready);
endinterface

interface hill_out_if import hill_pkg::*; ();
  logic    valid;
  logic    ready;
  letter_t letter_out;
  logic    final_result;
  logic    key_error;

  modport source(output valid, output letter_out, output final_result, output key_error,
                 input ready);
  modport sink(input valid, input letter_out, input final_result, input key_error,
               output ready);
endinterface

@@ hw/rtl/hill_ctrl.sv @@
// ---------------------------------------------------------------------------
// Hill cipher controller
// Pairs incoming letters and sequences the multiply and reduce steps.
// ---------------------------------------------------------------------------
module hill_ctrl import hill_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_eom,
  input  logic decrypt_mode,
  input  logic obuf_empty,
  output logic in_ready,
  output logic obuf_load,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_RED  = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  localparam logic [2:0] LAST_ENC = 3'd3;
  localparam logic [2:0] LAST_DEC = 3'd7;

  state_t     state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic       mode_r, mode_nxt;
  logic       holding_r, holding_nxt;
  logic [2:0] last_step;

  function automatic op_t step_op(input logic mode, input logic [2:0] step);
    op_t op;
    unique case ({mode, step})
      4'b0000: op = OP_E_AX;
      4'b0001: op = OP_E_BY;
      4'b0010: op = OP_E_CX;
      4'b0011: op = OP_E_DY;
      4'b1000: op = OP_D_BC;
      4'b1001: op = OP_D_AD;
      4'b1010: op = OP_D_BY;
      4'b1011: op = OP_D_DX;
      4'b1100: op = OP_D_R0;
      4'b1101: op = OP_D_CX;
      4'b1110: op = OP_D_AY;
      4'b1111: op = OP_D_R1;
      default: op = OP_E_AX;
    endcase
    return op;
  endfunction

  assign last_step = mode_r ? LAST_DEC : LAST_ENC;

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    mode_nxt    = mode_r;
    holding_nxt = holding_r;
    in_ready    = 1'b0;
    obuf_load   = 1'b0;
    cmd         = '0;
    cmd.op      = step_op(mode_r, step_r);
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (holding_r || in_eom) begin
            // The pair is complete; a lone final letter is padded.
            cmd.capture = 1'b1;
            cmd.pad     = !holding_r;
            holding_nxt = 1'b0;
            step_nxt    = '0;
            mode_nxt    = decrypt_mode;
            state_nxt   = S_MUL;
          end else begin
            cmd.hold_first = 1'b1;
            holding_nxt    = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_RED;
      end
      S_RED: begin
        cmd.red_en = 1'b1;
        if (step_r == last_step) begin
          state_nxt = S_LOAD;
        end else begin
          step_nxt  = step_r + 3'd1;
          state_nxt = S_MUL;
        end
      end
      S_LOAD: begin
        if (obuf_empty) begin
          obuf_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= '0;
      mode_r    <= 1'b0;
      holding_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      mode_r    <= mode_nxt;
      holding_r <= holding_nxt;
    end
  end

endmodule

@@ hw/rtl/hill_dp.sv @@
// ---------------------------------------------------------------------------
// Hill cipher datapath
// Shared multiply-accumulate unit with a mod 26 reduction stage.
// ---------------------------------------------------------------------------
module hill_dp import hill_pkg::*; (
  input  logic         clk,
  input  letter_t      in_letter,
  input  logic         in_eom,
  input  key_t         key,
  input  cmd_t         cmd,
  output result_pair_t res
);

  letter_t    held_r, x_r, y_r;
  letter_t    t_r, u_r, r0_r, r1_r, inv_r;
  logic       fin_r, err_r;
  logic [9:0] prod_r;
  letter_t    sadd_r;

  letter_t    ka, kb, kc, kd, in_red;
  letter_t    op_p, op_q, op_s;
  letter_t    red_val, inv_val;

  function automatic letter_t red_letter(input letter_t v);
    return (v >= MODULUS) ? v - MODULUS : v;
  endfunction

  function automatic letter_t neg_mod(input letter_t v);
    return (v == '0) ? '0 : MODULUS - v;
  endfunction

  // Reciprocal estimate of v / 26, at most one short, then one correction.
  function automatic letter_t mod26(input logic [9:0] v);
    logic [17:0] est;
    logic [4:0]  quo;
    logic [9:0]  rem;
    est = {8'd0, v} * 18'd315;
    quo = est[17:13];
    rem = v - ({5'd0, quo} * 10'd26);
    if (rem >= {5'd0, MODULUS}) begin
      rem = rem - {5'd0, MODULUS};
    end
    return rem[4:0];
  endfunction

  function automatic letter_t inv_tab(input letter_t v);
    letter_t r;
    case (v)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  assign ka     = red_letter(key.a);
  assign kb     = red_letter(key.b);
  assign kc     = red_letter(key.c);
  assign kd     = red_letter(key.d);
  assign in_red = red_letter(in_letter);

  always_comb begin
    op_p = '0;
    op_q = '0;
    op_s = '0;
    unique case (cmd.op)
      OP_E_AX: begin op_p = ka;    op_q = x_r;  op_s = '0;           end
      OP_E_BY: begin op_p = kb;    op_q = y_r;  op_s = t_r;          end
      OP_E_CX: begin op_p = kc;    op_q = x_r;  op_s = '0;           end
      OP_E_DY: begin op_p = kd;    op_q = y_r;  op_s = t_r;          end
      OP_D_BC: begin op_p = kb;    op_q = kc;   op_s = '0;           end
      OP_D_AD: begin op_p = ka;    op_q = kd;   op_s = neg_mod(t_r); end
      OP_D_BY: begin op_p = kb;    op_q = y_r;  op_s = '0;           end
      OP_D_DX: begin op_p = kd;    op_q = x_r;  op_s = neg_mod(t_r); end
      OP_D_R0: begin op_p = inv_r; op_q = u_r;  op_s = '0;           end
      OP_D_CX: begin op_p = kc;    op_q = x_r;  op_s = '0;           end
      OP_D_AY: begin op_p = ka;    op_q = y_r;  op_s = neg_mod(t_r); end
      OP_D_R1: begin op_p = inv_r; op_q = u_r;  op_s = '0;           end
      default: begin op_p = '0;    op_q = '0;   op_s = '0;           end
    endcase
  end

  assign red_val = mod26(prod_r + {5'd0, sadd_r});
  assign inv_val = inv_tab(red_val);

  always_ff @(posedge clk) begin
    if (cmd.hold_first) begin
      held_r <= in_red;
    end
    if (cmd.capture) begin
      x_r   <= cmd.pad ? in_red : held_r;
      y_r   <= cmd.pad ? PAD_LETTER : in_red;
      fin_r <= in_eom;
      err_r <= 1'b0;
    end
    if (cmd.mul_en) begin
      prod_r <= {5'd0, op_p} * {5'd0, op_q};
      sadd_r <= op_s;
    end
    if (cmd.red_en) begin
      case (cmd.op) inside
        OP_E_AX, OP_E_CX, OP_D_BC, OP_D_BY, OP_D_CX: t_r <= red_val;
        OP_E_BY, OP_D_R0: r0_r <= red_val;
        OP_E_DY, OP_D_R1: r1_r <= red_val;
        OP_D_DX, OP_D_AY: u_r <= red_val;
        OP_D_AD: begin
          inv_r <= inv_val;
          err_r <= (inv_val == '0);
        end
        default: ;
      endcase
    end
  end

  // A singular decrypt key forces both letters to zero.
  assign res.r0.letter = err_r ? '0 : r0_r;
  assign res.r0.fin    = 1'b0;
  assign res.r0.err    = err_r;
  assign res.r1.letter = err_r ? '0 : r1_r;
  assign res.r1.fin    = fin_r;
  assign res.r1.err    = err_r;

endmodule

@@ hw/rtl/hill_obuf.sv @@
// ---------------------------------------------------------------------------
// Hill cipher output buffer
// Two-entry buffer that holds a result pair and drains it one word at a time.
// ---------------------------------------------------------------------------
module hill_obuf import hill_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  result_pair_t din,
  input  logic         out_ready,
  output logic         out_valid,
  output result_t      head,
  output logic         empty
);

  logic [1:0] count_r;
  result_t    e0_r, e1_r;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign empty     = (count_r == 2'd0);
  assign pop       = out_valid && out_ready;
  assign head      = e0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else if (load) begin
      count_r <= 2'd2;
    end else if (pop) begin
      count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      e0_r <= din.r0;
      e1_r <= din.r1;
    end else if (pop) begin
      e0_r <= e1_r;
    end
  end

endmodule

@@ hw/rtl/hill_cipher_2x2_mod26.sv @@
// ---------------------------------------------------------------------------
// Hill cipher 2x2 mod 26, top level
// A first letter is only held. A completing letter blocks input while the shared
// multiply/reduce unit works on the pair and until the pair is loaded into the output
// buffer, so a new pair is not taken before the previous one is finished; loading waits
// while the output buffer still holds words from the previous pair.
// Synchronous active-low reset restores the identity key, encrypt mode, no held letter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hill_cipher_2x2_mod26 import hill_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  hill_in_if.sink               in_ch,
  hill_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Letters arrive one word at a time and are collected into pairs. The
  // first letter of a pair is simply held. When the second letter arrives,
  // or a final letter arrives alone and is padded with X, the controller runs
  // the datapath through a short sequence of multiply-accumulate steps: four
  // in encrypt mode, eight in decrypt mode, where the determinant and its
  // inverse are formed first. Each step passes through the multiplier and
  // then the mod 26 reduction.
  //
  // The finished pair is moved into a two-word output buffer, so the next
  // letter can be accepted while the previous results still drain. The
  // controller only waits before loading if the buffer still holds words.

  key_t         key_r;
  logic         dec_r;
  cmd_t         cmd;
  logic         obuf_load;
  logic         obuf_empty;
  result_pair_t res_pair;
  result_t      head;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r.a <= 5'd1;
      key_r.b <= 5'd0;
      key_r.c <= 5'd0;
      key_r.d <= 5'd1;
      dec_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KEY_A:   key_r.a <= cfg_wdata;
        CFG_KEY_B:   key_r.b <= cfg_wdata;
        CFG_KEY_C:   key_r.c <= cfg_wdata;
        CFG_KEY_D:   key_r.d <= cfg_wdata;
        CFG_DECRYPT: dec_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  hill_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_eom       (in_ch.end_of_message),
    .decrypt_mode (dec_r),
    .obuf_empty   (obuf_empty),
    .in_ready     (in_ch.ready),
    .obuf_load    (obuf_load),
    .cmd          (cmd)
  );

  hill_dp u_dp (
    .clk       (clk),
    .in_letter (in_ch.letter_in),
    .in_eom    (in_ch.end_of_message),
    .key       (key_r),
    .cmd       (cmd),
    .res       (res_pair)
  );

  hill_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (obuf_load),
    .din       (res_pair),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .head      (head),
    .empty     (obuf_empty)
  );

  assign out_ch.letter_out   = head.letter;
  assign out_ch.final_result = head.fin;
  assign out_ch.key_error    = head.err;

  // The buffer is only refilled once both words of the last pair are gone.
  `HILL_ASSERT_IMPL(a_load_when_empty, obuf_load, obuf_empty, "output buffer overwritten")

  // Every offered word is a reduced letter.
  `HILL_ASSERT_IMPL(a_letter_range, out_ch.valid, out_ch.letter_out < MODULUS, "bad letter")

  // A key error always comes with letter zero.
  `HILL_ASSERT_IMPL(a_err_letter, out_ch.valid && out_ch.key_error, out_ch.letter_out == '0, "err")

endmodule
